// ===== design/open_address_hash_table_defines.svh =====
// assertion macros for the open address hash table checker
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OAHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/oaht_pkg.sv =====
// shared types and constants of the open address hash table
package oaht_pkg;

  localparam int KEY_W          = 16;
  localparam int VAL_W          = 16;
  localparam int CFG_W          = 9;
  localparam int SLOT_W         = 8;
  localparam int COLL_W         = 9;
  localparam int ST_W           = 2;
  localparam int DEF_CAPACITY   = 256;
  localparam int TABLE_SIZE_RST = 256;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_FIND   = 1'b1;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                    func;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [COLL_W-1:0] collisions;
  } out_item_t;

  typedef struct packed {
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } mem_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic div_step;
    logic rd;
    logic chk;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic full_now;
    logic div_last;
    logic chk_done;
  } dp_status_t;

endpackage

// ===== design/oaht_ctrl.sv =====
// controller state machine of the open address hash table
module oaht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  oaht_pkg::dp_status_t st,
  output oaht_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import oaht_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start && !st.full_now) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (st.div_last) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = st.chk_done ? S_IDLE : S_READ;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_READ: begin
        cmd.rd = 1'b1;
      end
      S_CHECK: begin
        cmd.chk = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== design/oaht_dp.sv =====
// datapath of the open address hash table: slot memory, key reduction and probing
module oaht_dp #(
  parameter int CAPACITY = oaht_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  oaht_pkg::ctrl_cmd_t                 cmd,
  output oaht_pkg::dp_status_t                st,
  input  oaht_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [oaht_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                out_strobe,
  output oaht_pkg::out_item_t                 out_data
);
  import oaht_pkg::*;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int SIZE_W   = $clog2(CAPACITY + 1);
  localparam int CW       = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
  localparam int BIT_W    = $clog2(KEY_W);
  localparam int RST_SIZE = (TABLE_SIZE_RST > CAPACITY) ? CAPACITY : TABLE_SIZE_RST;

  mem_word_t            mem_r [CAPACITY];
  mem_word_t            rd_r;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SIZE_W-1:0]    size_nxt;
  logic [SIZE_W-1:0]    count_r;
  logic [SIZE_W-1:0]    pos_r;
  logic [SIZE_W-1:0]    pos_nxt;
  logic [SIZE_W-1:0]    d_r;
  logic [SIZE_W-1:0]    d_nxt;
  logic [BIT_W-1:0]     bit_cnt_r;
  logic                 func_r;
  logic [KEY_W-1:0]     key_r;
  logic [VAL_W-1:0]     value_r;
  logic                 out_strobe_r;
  out_item_t            out_data_r;

  logic [CW-1:0]        cfg_ext;
  logic [SIZE_W:0]      size_ext;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W-1:0]    rem_nxt;
  logic [SIZE_W:0]      sum;
  logic                 occ;
  logic                 match;
  logic                 exhaust;
  logic                 is_find;
  logic                 ins_free;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  mem_word_t            mem_wd;
  out_item_t            res;

  // effective size of a configuration beat
  always_comb begin
    cfg_ext = CW'(cfg_wdata);
    if (cfg_ext == '0) begin
      size_nxt = SIZE_W'(1);
    end else if (cfg_ext > CW'(CAPACITY)) begin
      size_nxt = SIZE_W'(CAPACITY);
    end else begin
      size_nxt = SIZE_W'(cfg_ext);
    end
  end

  // key modulo size, one key bit per step
  always_comb begin
    size_ext = {1'b0, size_r};
    trial    = {pos_r, key_r[BIT_W'(KEY_W - 1) - bit_cnt_r]};
    if (trial >= size_ext) begin
      rem_nxt = SIZE_W'(trial - size_ext);
    end else begin
      rem_nxt = trial[SIZE_W-1:0];
    end
  end

  // probe check
  always_comb begin
    occ      = rd_r.occ;
    match    = (rd_r.key == key_r);
    is_find  = (func_r == FUNC_FIND);
    d_nxt    = d_r + SIZE_W'(1);
    exhaust  = (d_nxt == size_r);
    ins_free = !is_find && !occ;
    sum      = (SIZE_W + 1)'(pos_r) + (SIZE_W + 1)'(d_nxt);
    if (sum >= size_ext) begin
      pos_nxt = SIZE_W'(sum - size_ext);
    end else begin
      pos_nxt = sum[SIZE_W-1:0];
    end

    res = '0;
    if (!occ) begin
      res.status     = is_find ? ST_MISS : ST_OK;
      res.slot       = is_find ? '0 : SLOT_W'(pos_r);
      res.collisions = COLL_W'(d_r);
    end else if (is_find && match) begin
      res.status     = ST_OK;
      res.slot       = SLOT_W'(pos_r);
      res.collisions = COLL_W'(d_r);
    end else begin
      res.status     = is_find ? ST_MISS : ST_FULL;
      res.collisions = COLL_W'(size_r);
    end
  end

  always_comb begin
    st.clr_done = (clr_addr_r == ADDR_W'(CAPACITY - 1));
    st.full_now = (in_data.func == FUNC_INSERT) && (count_r >= size_r);
    st.div_last = (bit_cnt_r == BIT_W'(KEY_W - 1));
    st.chk_done = !occ || (is_find && match) || exhaust;
  end

  // memory port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_r[ADDR_W-1:0];
    mem_wd = '{occ: 1'b1, key: key_r, value: value_r};
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else if (cmd.chk && ins_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (cmd.rd) rd_r <= mem_r[pos_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      size_r       <= SIZE_W'(RST_SIZE);
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (cfg_we) size_r <= size_nxt;
      if (cmd.chk && ins_free) count_r <= count_r + SIZE_W'(1);
      out_strobe_r <= (cmd.accept && st.full_now) || (cmd.chk && st.chk_done);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r    <= in_data.func;
      key_r     <= in_data.key;
      value_r   <= in_data.value;
      pos_r     <= '0;
      d_r       <= '0;
      bit_cnt_r <= '0;
      if (st.full_now) out_data_r <= '{status: ST_FULL, slot: '0, collisions: '0};
    end
    if (cmd.div_step) begin
      pos_r     <= rem_nxt;
      bit_cnt_r <= bit_cnt_r + BIT_W'(1);
    end
    if (cmd.chk) begin
      if (st.chk_done) begin
        out_data_r <= res;
      end else begin
        d_r   <= d_nxt;
        pos_r <= pos_nxt;
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== design/open_address_hash_table.sv =====
// Open-addressing key/value table with growing probe steps (1, 2, 3 and so on)
// modulo the configured size. After reset a clearing pass marks all CAPACITY
// slots empty, one slot per cycle, and busy stays high until it is done. An item
// is taken when start is high and busy is low. An insert into a table whose count
// has reached the size answers in the next cycle. Every other item first has its
// key reduced modulo the size one bit per cycle in S_DIV; then each probe does a
// registered memory read in S_READ and the compare in S_CHECK. The result strobe
// comes in the cycle after the last probe, as busy drops; for these items
// collisions counts the failed probes, or is the size when every probe fails. The
// result is shown for exactly one cycle on out_strobe and cannot be held off.
// table_size may be written only while busy is low and no result is pending.
module open_address_hash_table #(
  parameter int CAPACITY = oaht_pkg::DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  oaht_pkg::in_item_t         in_data,
  output logic                       out_strobe,
  output oaht_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [oaht_pkg::CFG_W-1:0] cfg_wdata
);
  import oaht_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  oaht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  oaht_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== design/oaht_checker.sv =====
// port checker of the open address hash table and its bind
`include "open_address_hash_table_defines.svh"

module oaht_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_strobe,
  input oaht_pkg::out_item_t        out_data
);
  import oaht_pkg::*;

  `OAHT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_strobe, "accepted beat lost")
  `OAHT_ASSERT_NOW(a_result_idle, out_strobe, !busy, "result beat while busy")
  `OAHT_ASSERT_NOW(a_status_code, out_strobe, out_data.status <= ST_FULL, "bad status code")
  `OAHT_ASSERT_NOW(a_slot_zero, out_strobe && out_data.status != ST_OK, out_data.slot == '0, "slot set on failure")

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (.*);

// ===== sim/open_address_hash_table_tb.sv =====
// self-checking testbench for the open address hash table: directed cases, then random traffic
module open_address_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaht_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int DRAIN_CYCLES = 600;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_data   = '0;
  logic                 out_strobe;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  bit                   occupied   [CAP];
  logic [KEY_W-1:0]     stored_key [CAP];
  int                   stored_count  = 0;
  int                   table_size_q  = TABLE_SIZE_RST;
  out_item_t            pending_results [$];
  logic [KEY_W-1:0]     known_keys [$];
  int                   error_count   = 0;
  bit                   sender_idles  = 1'b1;

  open_address_hash_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int effective_size();
    if (table_size_q == 0) return 1;
    if (table_size_q > CAP) return CAP;
    return table_size_q;
  endfunction

  function automatic out_item_t predict_lookup(input in_item_t it);
    out_item_t r;
    int        size;
    int        pos;
    int        d;
    size = effective_size();
    pos = it.key % size;
    d = 0;
    r.status = (it.func == FUNC_INSERT) ? ST_FULL : ST_MISS;
    r.slot = '0;
    r.collisions = COLL_W'(size);
    if (it.func == FUNC_INSERT && stored_count >= size) begin
      r.collisions = '0;
      return r;
    end
    for (int i = 0; i < size; i++) begin
      if (!occupied[pos]) begin
        if (it.func == FUNC_INSERT) begin
          occupied[pos] = 1'b1;
          stored_key[pos] = it.key;
          if (stored_count < CAP) stored_count++;
          known_keys.push_back(it.key);
          r.status = ST_OK;
          r.slot = SLOT_W'(pos);
        end else begin
          r.status = ST_MISS;
        end
        r.collisions = COLL_W'(d);
        return r;
      end
      if (it.func == FUNC_FIND && stored_key[pos] == it.key) begin
        r.status = ST_OK;
        r.slot = SLOT_W'(pos);
        r.collisions = COLL_W'(d);
        return r;
      end
      d++;
      pos = (pos + d) % size;
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_error("result beat with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_error($sformatf("status got %0d want %0d", out_data.status, want.status));
        if (out_data.slot !== want.slot)
          report_error($sformatf("slot got %0d want %0d", out_data.slot, want.slot));
        if (out_data.collisions !== want.collisions)
          report_error($sformatf("collisions got %0d want %0d",
                                 out_data.collisions, want.collisions));
      end
    end
  end

  task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    in_item_t it;
    it.func = func;
    it.key = key;
    it.value = value;
    while (sender_idles && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      in_data <= '{func: 1'($urandom), key: KEY_W'($urandom), value: VAL_W'($urandom)};
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_lookup(it));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_table_size(input int v);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    table_size_q = v & ((1 << CFG_W) - 1);
  endtask

  task automatic test_tiny_table();
    write_table_size(0);
    send_item(FUNC_INSERT, 16'hFFFF, 16'h7FFF);
    send_item(FUNC_INSERT, 16'h0005, 16'h8000);
    send_item(FUNC_FIND,   16'hFFFF, 16'h0000);
    send_item(FUNC_FIND,   16'h0007, 16'hFFFF);
  endtask

  task automatic test_probe_exhaustion();
    write_table_size(3);
    send_item(FUNC_INSERT, 16'h0000, 16'h1234);
    send_item(FUNC_INSERT, 16'h0003, 16'hFFFF);
    send_item(FUNC_FIND,   16'h0002, 16'h0000);
    send_item(FUNC_FIND,   16'h0006, 16'h0000);
    send_item(FUNC_FIND,   16'h0000, 16'h0000);
    write_table_size(2);
    send_item(FUNC_INSERT, 16'h0001, 16'h0001);
    send_item(FUNC_FIND,   16'hFFFF, 16'h0000);
  endtask

  task automatic test_size_clamp();
    write_table_size(511);
    send_item(FUNC_INSERT, 16'h00FF, 16'h0000);
    send_item(FUNC_INSERT, 16'h01FF, 16'h7FFF);
    send_item(FUNC_INSERT, 16'h00FF, 16'h8000);
    send_item(FUNC_FIND,   16'h00FF, 16'h0000);
    send_item(FUNC_FIND,   16'h01FF, 16'h0000);
    send_item(FUNC_FIND,   16'h8000, 16'hFFFF);
    write_table_size(256);
    send_item(FUNC_INSERT, 16'hAAAA, 16'h5555);
    send_item(FUNC_FIND,   16'hAAAA, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int               sz;
    int               eff;
    int               roll;
    logic [KEY_W-1:0] key;
    for (int p = 0; p < 16; p++) begin
      sz = (p % 6 == 5) ? $urandom_range(200, 511) : $urandom_range(1, 8 + p * 12);
      write_table_size(sz);
      eff = effective_size();
      sender_idles = (p != 7);
      repeat (85) begin
        if ($urandom_range(0, 99) < 3) wait_for_results();
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0, 1: key = KEY_W'($urandom);
          2: key = KEY_W'($urandom_range(0, 2 * eff));
          default: begin
            if (known_keys.size() != 0)
              key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            else
              key = KEY_W'($urandom);
          end
        endcase
        if (roll < 30) begin
          send_item(FUNC_INSERT, key, VAL_W'($urandom));
        end else begin
          if (roll < 70 && known_keys.size() != 0)
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
          send_item(FUNC_FIND, key, VAL_W'($urandom));
        end
      end
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_tiny_table();
    test_probe_exhaustion();
    test_size_clamp();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #64_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
